>>> rtl/lbc_pkg.sv
// Package for the LRU block buffer cache core.
// Holds the slot count, the request/result structs, the slot entry type and codes.
// Used by every file in rtl/; depends on nothing.
package lbc_pkg;

  localparam int SLOTS     = 32;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int COUNT_MAX = 255;

  typedef enum logic [1:0] {
    KIND_GET     = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_WRITE   = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } disk_req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_UNREF   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  device;
    logic [23:0] block_number;
    logic [4:0]  slot_index;
  } req_t;

  typedef struct packed {
    logic [4:0] slot;
    logic       hit;
    logic [1:0] disk_request;
    logic [1:0] status;
  } result_t;

  // One buffer slot as it travels around the ring of cells.
  typedef struct packed {
    logic [SLOT_W-1:0] sid;
    logic [3:0]        dev;
    logic [23:0]       blk;
    logic              valid;
    logic              dirty;
    logic [7:0]        count;
  } entry_t;

  // Control from the sequencer to the ring.
  typedef struct packed {
    logic   shift;
    entry_t tail;
  } ring_ctl_t;

  function automatic logic [4:0] slot_field(input logic [SLOT_W-1:0] sid);
    logic [31:0] w;
    w = 32'(sid);
    return w[4:0];
  endfunction

endpackage

>>> rtl/lru_block_buffer_cache_core.sv
// Top level of the LRU block buffer cache: a ring of lbc_cell slots in recency
// order and the lbc_ctrl sequencer. Depends on lbc_pkg, lbc_cell and lbc_ctrl.
//
//   channel   ports                   direction  handshake
//   request   start, busy, req        in         taken when start is high and busy low
//   result    done, result            out        one-cycle strobe, no back-pressure
//
// Every in-range request takes a search rotation of the single ring of cells, a decision
// step and, when the store changes, a write-back rotation; busy stays high meanwhile.
// Synchronous reset puts the highest slot at the front with all tags and marks clear.
// The receiver cannot stall: each result is shown for exactly one cycle.
module lru_block_buffer_cache_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lbc_pkg::req_t     req,
  output logic              busy,
  output logic              done,
  output lbc_pkg::result_t  result
);

  lbc_pkg::entry_t    ring [lbc_pkg::SLOTS];
  lbc_pkg::ring_ctl_t ctl;

  for (genvar i = 0; i < lbc_pkg::SLOTS; i++) begin : g_cell
    lbc_pkg::entry_t nbr;
    if (i == lbc_pkg::SLOTS - 1) begin : g_tail
      assign nbr = ctl.tail;
    end else begin : g_body
      assign nbr = ring[i+1];
    end
    lbc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (ctl.shift),
      .init_sid (lbc_pkg::SLOT_W'(lbc_pkg::SLOTS - 1 - i)),
      .nbr      (nbr),
      .q        (ring[i])
    );
  end

  lbc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .head   (ring[0]),
    .busy   (busy),
    .done   (done),
    .result (result),
    .ctl    (ctl)
  );

endmodule

>>> rtl/lbc_cell.sv
// One cell of the recency ring: holds the slot at one recency position.
// Depends on lbc_pkg for the entry type.
module lbc_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      shift,
  input  logic [lbc_pkg::SLOT_W-1:0] init_sid,
  input  lbc_pkg::entry_t           nbr,
  output lbc_pkg::entry_t           q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.sid   <= init_sid;
      q.dev   <= '0;
      q.blk   <= '0;
      q.valid <= 1'b0;
      q.dirty <= 1'b0;
      q.count <= '0;
    end else if (shift) begin
      q <= nbr;
    end
  end

endmodule

>>> rtl/lbc_ctrl.sv
// Sequencer for the LRU block buffer cache: scans the ring once to search,
// then, if the store changes, rotates it once more to write the change back. Depends on lbc_pkg.
module lbc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  lbc_pkg::req_t       req,
  input  lbc_pkg::entry_t     head,
  output logic                busy,
  output logic                done,
  output lbc_pkg::result_t    result,
  output lbc_pkg::ring_ctl_t  ctl
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_APPLY  = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_EDIT,
    MODE_FRONT
  } mode_t;

  localparam logic [lbc_pkg::SLOT_W-1:0] LAST = lbc_pkg::SLOT_W'(lbc_pkg::SLOTS - 1);

  state_t                      state;
  lbc_pkg::req_t               op;
  logic [lbc_pkg::SLOT_W-1:0]  k;
  logic                        m_found;
  logic [lbc_pkg::SLOT_W-1:0]  m_pos;
  lbc_pkg::entry_t             m_ent;
  logic                        v_found;
  logic [lbc_pkg::SLOT_W-1:0]  v_pos;
  lbc_pkg::entry_t             v_ent;
  mode_t                       mode;
  logic [lbc_pkg::SLOT_W-1:0]  tpos;
  lbc_pkg::entry_t             newent;
  lbc_pkg::entry_t             hold;

  mode_t                       d_mode;
  logic [lbc_pkg::SLOT_W-1:0]  d_pos;
  lbc_pkg::entry_t             d_ent;
  lbc_pkg::result_t            d_res;

  logic                        tag_match;
  logic                        sid_match;
  logic                        eligible;
  logic                        out_of_range;

  assign busy = (state != S_IDLE);

  assign tag_match    = (head.dev == op.device) && (head.blk == op.block_number);
  assign sid_match    = (32'(head.sid) == 32'(op.slot_index));
  assign eligible     = (head.count == 8'd0) && !head.dirty;
  assign out_of_range = (req.kind != lbc_pkg::KIND_GET) &&
                        (32'(req.slot_index) >= 32'(lbc_pkg::SLOTS));

  // Ring feed: plain rotation, except where the change is written back.
  always_comb begin
    ctl.shift = (state == S_SCAN) || (state == S_APPLY);
    ctl.tail  = head;
    if (state == S_APPLY) begin
      if (mode == MODE_EDIT) begin
        if (k == tpos) ctl.tail = newent;
      end else if (mode == MODE_FRONT) begin
        // Move to front: the target goes first, the ones ahead of it slide back one.
        if (k == '0) ctl.tail = newent;
        else if (k <= tpos) ctl.tail = hold;
      end
    end
  end

  // Outcome of the search, worked out from the snapshots taken during the scan.
  always_comb begin
    d_mode             = MODE_NONE;
    d_pos              = m_pos;
    d_ent              = m_ent;
    d_res.slot         = lbc_pkg::slot_field(m_ent.sid);
    d_res.hit          = 1'b0;
    d_res.disk_request = lbc_pkg::REQ_NONE;
    d_res.status       = lbc_pkg::ST_OK;
    case (op.kind)
      lbc_pkg::KIND_GET: begin
        if (m_found) begin
          d_res.hit = 1'b1;
          if (32'(m_ent.count) >= 32'(lbc_pkg::COUNT_MAX)) begin
            d_res.status = lbc_pkg::ST_FULL;
          end else begin
            d_mode       = MODE_EDIT;
            d_ent.count  = m_ent.count + 8'd1;
            d_res.disk_request = m_ent.valid ? lbc_pkg::REQ_NONE : lbc_pkg::REQ_READ;
          end
        end else if (v_found) begin
          d_mode             = MODE_EDIT;
          d_pos              = v_pos;
          d_ent.sid          = v_ent.sid;
          d_ent.dev          = op.device;
          d_ent.blk          = op.block_number;
          d_ent.valid        = 1'b0;
          d_ent.dirty        = 1'b0;
          d_ent.count        = 8'd1;
          d_res.slot         = lbc_pkg::slot_field(v_ent.sid);
          d_res.disk_request = lbc_pkg::REQ_READ;
        end else begin
          d_res.slot   = 5'd0;
          d_res.status = lbc_pkg::ST_NO_FREE;
        end
      end
      lbc_pkg::KIND_RELEASE: begin
        if (m_ent.count == 8'd0) begin
          d_res.status = lbc_pkg::ST_UNREF;
        end else begin
          d_ent.count = m_ent.count - 8'd1;
          d_mode      = (m_ent.count == 8'd1) ? MODE_FRONT : MODE_EDIT;
        end
      end
      lbc_pkg::KIND_WRITE: begin
        d_mode             = MODE_EDIT;
        d_ent.dirty        = 1'b1;
        d_res.disk_request = lbc_pkg::REQ_WRITE;
      end
      default: begin
        d_mode      = MODE_EDIT;
        d_ent.valid = 1'b1;
        d_ent.dirty = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      k     <= '0;
      mode  <= MODE_NONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= start && out_of_range;
          if (start) begin
            op      <= req;
            k       <= '0;
            m_found <= 1'b0;
            v_found <= 1'b0;
            if (out_of_range) begin
              result.slot         <= req.slot_index;
              result.hit          <= 1'b0;
              result.disk_request <= lbc_pkg::REQ_NONE;
              result.status       <= lbc_pkg::ST_OK;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          done <= 1'b0;
          // The head shows recency position k in this cycle.
          if (op.kind == lbc_pkg::KIND_GET) begin
            if (!m_found && tag_match) begin
              m_found <= 1'b1;
              m_pos   <= k;
              m_ent   <= head;
            end
            // The last eligible slot seen is the least recent one.
            if (eligible) begin
              v_found <= 1'b1;
              v_pos   <= k;
              v_ent   <= head;
            end
          end else if (sid_match) begin
            m_found <= 1'b1;
            m_pos   <= k;
            m_ent   <= head;
          end
          if (k == LAST) begin
            k     <= '0;
            state <= S_DECIDE;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_DECIDE: begin
          mode   <= d_mode;
          tpos   <= d_pos;
          newent <= d_ent;
          result <= d_res;
          if (d_mode == MODE_NONE) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            done  <= 1'b0;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          hold <= head;
          if (k == LAST) begin
            k     <= '0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            k    <= k + 1'b1;
            done <= 1'b0;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/lbc_checker.sv
// Port-level checks for lru_block_buffer_cache_core, bound to the top level.
// Depends on lbc_pkg for the codes.
module lbc_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input lbc_pkg::req_t     req,
  input logic              done,
  input lbc_pkg::result_t  result
);

  // An in-range request keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && ((req.kind == lbc_pkg::KIND_GET) ||
                        (32'(req.slot_index) < 32'(lbc_pkg::SLOTS)))) |=> busy)
    else $error("accepted request did not raise busy");

  // The end of a busy period always delivers its result.
  a_result_at_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.hit) |-> ((result.status == lbc_pkg::ST_OK) ||
                              (result.status == lbc_pkg::ST_FULL)))
    else $error("hit reported with a bad status");

  a_no_free: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == lbc_pkg::ST_NO_FREE)) |->
      ((result.slot == 5'd0) && !result.hit &&
       (result.disk_request == lbc_pkg::REQ_NONE)))
    else $error("no-free result carries a slot or a disk request");

  a_write_req: assert property (@(posedge clk) disable iff (rst)
    (done && (result.disk_request == lbc_pkg::REQ_WRITE)) |->
      ((result.status == lbc_pkg::ST_OK) && !result.hit))
    else $error("disk write with a bad status or hit");

endmodule

bind lru_block_buffer_cache_core lbc_checker u_lbc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .req    (req),
  .done   (done),
  .result (result)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_block_buffer_cache_core: directed and random requests.
// Holds its own shadow of the slot store in a scoreboard class; depends on lbc_pkg and the RTL.

class cache_scoreboard;
  logic [3:0]       tag_dev [lbc_pkg::SLOTS];
  logic [23:0]      tag_blk [lbc_pkg::SLOTS];
  bit               valid   [lbc_pkg::SLOTS];
  bit               dirty   [lbc_pkg::SLOTS];
  int unsigned      refs    [lbc_pkg::SLOTS];
  // Position 0 holds the most recently freed slot.
  int unsigned      order   [lbc_pkg::SLOTS];
  lbc_pkg::result_t owed_results [$];
  int errors = 0;
  int printed = 0;
  int hits = 0;
  int misses = 0;
  int no_free = 0;
  int full_hits = 0;
  int unref_releases = 0;
  int writes = 0;
  int dones = 0;

  function new();
    for (int i = 0; i < lbc_pkg::SLOTS; i++) begin
      tag_dev[i] = '0;
      tag_blk[i] = '0;
      valid[i]   = 1'b0;
      dirty[i]   = 1'b0;
      refs[i]    = 0;
      order[i]   = lbc_pkg::SLOTS - 1 - i;
    end
  endfunction

  // Works out the result of an accepted request and updates the shadow store.
  function void note_request(lbc_pkg::req_t r);
    lbc_pkg::result_t res;
    int unsigned s;
    int pos;
    bit found;
    res = '0;
    found = 1'b0;
    if (r.kind == lbc_pkg::KIND_GET) begin
      for (int i = 0; i < lbc_pkg::SLOTS && !found; i++) begin
        s = order[i];
        if (tag_dev[s] == r.device && tag_blk[s] == r.block_number) begin
          found = 1'b1;
          res.slot = s[4:0];
          res.hit = 1'b1;
          if (refs[s] >= lbc_pkg::COUNT_MAX) begin
            res.status = lbc_pkg::ST_FULL;
            full_hits++;
          end else begin
            refs[s]++;
            res.disk_request = valid[s] ? lbc_pkg::REQ_NONE : lbc_pkg::REQ_READ;
            hits++;
          end
        end
      end
      // A miss takes the least recent slot that is neither held nor dirty.
      for (int i = lbc_pkg::SLOTS - 1; i >= 0 && !found; i--) begin
        s = order[i];
        if (refs[s] == 0 && !dirty[s]) begin
          found = 1'b1;
          tag_dev[s] = r.device;
          tag_blk[s] = r.block_number;
          valid[s] = 1'b0;
          dirty[s] = 1'b0;
          refs[s] = 1;
          res.slot = s[4:0];
          res.disk_request = lbc_pkg::REQ_READ;
          misses++;
        end
      end
      if (!found) begin
        res.status = lbc_pkg::ST_NO_FREE;
        no_free++;
      end
    end else begin
      res.slot = r.slot_index;
      s = 32'(r.slot_index);
      if (s < lbc_pkg::SLOTS) begin
        case (r.kind)
          lbc_pkg::KIND_RELEASE: begin
            if (refs[s] == 0) begin
              res.status = lbc_pkg::ST_UNREF;
              unref_releases++;
            end else begin
              refs[s]--;
              if (refs[s] == 0) begin
                pos = 0;
                for (int i = 0; i < lbc_pkg::SLOTS; i++)
                  if (order[i] == s) pos = i;
                for (int i = pos; i > 0; i--)
                  order[i] = order[i - 1];
                order[0] = s;
              end
            end
          end
          lbc_pkg::KIND_WRITE: begin
            dirty[s] = 1'b1;
            res.disk_request = lbc_pkg::REQ_WRITE;
            writes++;
          end
          default: begin
            valid[s] = 1'b1;
            dirty[s] = 1'b0;
            dones++;
          end
        endcase
      end
    end
    owed_results.push_back(res);
  endfunction

  function void flag_field(string name, logic [31:0] want, logic [31:0] got);
    errors++;
    if (printed < 40) begin
      printed++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function void check_result(lbc_pkg::result_t got);
    lbc_pkg::result_t want;
    if (owed_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got %h", $time, got);
      return;
    end
    want = owed_results.pop_front();
    if (got.slot !== want.slot) flag_field("slot", 32'(want.slot), 32'(got.slot));
    if (got.hit !== want.hit) flag_field("hit", 32'(want.hit), 32'(got.hit));
    if (got.disk_request !== want.disk_request)
      flag_field("disk_request", 32'(want.disk_request), 32'(got.disk_request));
    if (got.status !== want.status)
      flag_field("status", 32'(want.status), 32'(got.status));
  endfunction
endclass

module tb;

  localparam int POOL = 40;
  localparam int ITEMS = 1200;
  localparam int QUIET_LIMIT = 3000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  lbc_pkg::req_t    req = '0;
  logic             busy;
  logic             done;
  lbc_pkg::result_t result;

  cache_scoreboard sb = new();
  int          quiet_cycles = 0;
  int          requests_sent = 0;
  int unsigned burst_left = 0;
  logic [3:0]  pool_dev [POOL];
  logic [23:0] pool_blk [POOL];

  lru_block_buffer_cache_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_request(req);
      if (done || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no request or result for %0d cycles", $time, QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Drives one request, waits until it is taken, then idles at the end of a burst.
  task automatic issue(input lbc_pkg::kind_t k, input logic [3:0] dev,
                       input logic [23:0] blk, input logic [4:0] idx);
    lbc_pkg::req_t r;
    r.kind = k;
    r.device = dev;
    r.block_number = blk;
    r.slot_index = idx;
    req <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 70)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Picks a held slot, or with want_io a dirty or still unread slot; any slot if none.
  function automatic logic [4:0] pick_slot(input bit want_io);
    logic [4:0] cand [$];
    for (int s = 0; s < lbc_pkg::SLOTS; s++)
      if (want_io ? (sb.dirty[s] || (!sb.valid[s] && sb.refs[s] != 0)) : sb.refs[s] != 0)
        cand.push_back(s[4:0]);
    if (cand.size() == 0) return 5'($urandom);
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  // Releases every reference and completes every pending write so the store is free again.
  task automatic drain_store();
    for (int s = 0; s < lbc_pkg::SLOTS; s++) begin
      while (sb.refs[s] != 0)
        issue(lbc_pkg::KIND_RELEASE, 4'($urandom), 24'($urandom), s[4:0]);
      if (sb.dirty[s]) issue(lbc_pkg::KIND_DONE, 4'($urandom), 24'($urandom), s[4:0]);
    end
  endtask

  initial begin
    int unsigned roll;
    int unsigned pick;
    bit saturated;
    saturated = 1'b0;
    pool_dev[0] = 4'h0;
    pool_blk[0] = 24'h000000;
    pool_dev[1] = 4'hF;
    pool_blk[1] = 24'hFFFFFF;
    for (int i = 2; i < POOL; i++) begin
      pool_dev[i] = 4'($urandom);
      pool_blk[i] = 24'($urandom);
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Every slot starts tagged device 0 block 0, so this hits a slot that is not valid.
    issue(lbc_pkg::KIND_GET, 4'h0, 24'h000000, 5'($urandom));
    issue(lbc_pkg::KIND_GET, 4'hF, 24'hFFFFFF, 5'($urandom));
    issue(lbc_pkg::KIND_DONE, 4'($urandom), 24'($urandom), 5'd0);
    issue(lbc_pkg::KIND_GET, 4'hF, 24'hFFFFFF, 5'($urandom));
    issue(lbc_pkg::KIND_WRITE, 4'($urandom), 24'($urandom), 5'd0);
    issue(lbc_pkg::KIND_GET, 4'hF, 24'hFFFFFF, 5'($urandom));
    issue(lbc_pkg::KIND_RELEASE, 4'($urandom), 24'($urandom), 5'd0);
    issue(lbc_pkg::KIND_RELEASE, 4'($urandom), 24'($urandom), 5'd0);
    issue(lbc_pkg::KIND_RELEASE, 4'($urandom), 24'($urandom), 5'd0);
    issue(lbc_pkg::KIND_RELEASE, 4'($urandom), 24'($urandom), 5'd0);
    issue(lbc_pkg::KIND_GET, 4'h0, 24'hFFFFFF, 5'($urandom));
    issue(lbc_pkg::KIND_GET, 4'hF, 24'h000000, 5'($urandom));
    issue(lbc_pkg::KIND_DONE, 4'($urandom), 24'($urandom), 5'd31);
    issue(lbc_pkg::KIND_RELEASE, 4'($urandom), 24'($urandom), 5'd31);
    issue(lbc_pkg::KIND_GET, 4'h0, 24'h000000, 5'($urandom));
    issue(lbc_pkg::KIND_WRITE, 4'($urandom), 24'($urandom), 5'd31);
    issue(lbc_pkg::KIND_DONE, 4'($urandom), 24'($urandom), 5'd31);
    issue(lbc_pkg::KIND_DONE, 4'($urandom), 24'($urandom), 5'd0);
    issue(lbc_pkg::KIND_RELEASE, 4'($urandom), 24'($urandom), 5'd1);
    issue(lbc_pkg::KIND_RELEASE, 4'($urandom), 24'($urandom), 5'd2);
    issue(lbc_pkg::KIND_RELEASE, 4'($urandom), 24'($urandom), 5'd31);
    issue(lbc_pkg::KIND_WRITE, 4'($urandom), 24'($urandom), 5'd16);
    issue(lbc_pkg::KIND_DONE, 4'($urandom), 24'($urandom), 5'd16);

    while (requests_sent < ITEMS) begin
      roll = $urandom_range(0, 99);
      if (!saturated && requests_sent > 400) begin
        // Push one block's count to its ceiling, then ask three times more.
        saturated = 1'b1;
        drain_store();
        pick = $urandom_range(0, POOL - 1);
        repeat (lbc_pkg::COUNT_MAX + 3)
          issue(lbc_pkg::KIND_GET, pool_dev[pick], pool_blk[pick], 5'($urandom));
        drain_store();
      end else if (roll < 10) begin
        // Hold more blocks than there are slots so that gets find no free slot.
        repeat (lbc_pkg::SLOTS + 4) begin
          if ($urandom_range(0, 7) == 0)
            issue(lbc_pkg::KIND_WRITE, 4'($urandom), 24'($urandom), 5'($urandom));
          else
            issue(lbc_pkg::KIND_GET, 4'($urandom), 24'($urandom), 5'($urandom));
        end
        drain_store();
      end else begin
        repeat (30) begin
          roll = $urandom_range(0, 99);
          if (roll < 40) begin
            pick = $urandom_range(0, POOL - 1);
            if ($urandom_range(0, 3) != 0)
              issue(lbc_pkg::KIND_GET, pool_dev[pick], pool_blk[pick], 5'($urandom));
            else
              issue(lbc_pkg::KIND_GET, 4'($urandom), 24'($urandom), 5'($urandom));
          end else if (roll < 68) begin
            issue(lbc_pkg::KIND_RELEASE, 4'($urandom), 24'($urandom),
                  ($urandom_range(0, 6) != 0) ? pick_slot(1'b0) : 5'($urandom));
          end else if (roll < 80) begin
            issue(lbc_pkg::KIND_WRITE, 4'($urandom), 24'($urandom), 5'($urandom));
          end else begin
            issue(lbc_pkg::KIND_DONE, 4'($urandom), 24'($urandom),
                  ($urandom_range(0, 9) < 7) ? pick_slot(1'b1) : 5'($urandom));
          end
        end
      end
    end

    start <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (2 * lbc_pkg::SLOTS + 4) @(posedge clk);
    $display("Sent %0d requests: %0d get hits, %0d misses, %0d with no free slot, %0d full.",
             requests_sent, sb.hits, sb.misses, sb.no_free, sb.full_hits);
    $display("Also %0d writes, %0d disk completions, %0d idle releases; %0d mismatches.",
             sb.writes, sb.dones, sb.unref_releases, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/lbc_pkg.sv
rtl/lbc_cell.sv
rtl/lbc_ctrl.sv
rtl/lru_block_buffer_cache_core.sv
rtl/lbc_checker.sv
tb/tb.sv
